/* rtl/core/gqam_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Quarter-annulus mapper package
// Widths, fixed-point constants, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package gqam_pkg;

    localparam int INDEX_BITS   = 10;
    localparam int COORD_BITS   = 32;
    localparam int ANG_BITS     = 30;
    localparam int SPAN_BITS    = COORD_BITS + 1;
    localparam int NUM_BITS     = INDEX_BITS + SPAN_BITS;
    localparam int CORDIC_STEPS = 16;
    localparam int CW           = ANG_BITS + 3;
    localparam int ZW           = ANG_BITS + 2;
    localparam int PW           = COORD_BITS + CW;

    localparam logic [ANG_BITS:0]   HALF_PI_Q30     = 31'd1686629713;
    localparam logic [ANG_BITS-1:0] CORDIC_GAIN_Q30 = 30'd652032874;

    typedef enum logic [1:0] {
        REG_X_MIN  = 2'd0,
        REG_X_MAX  = 2'd1,
        REG_N_COLS = 2'd2,
        REG_N_ROWS = 2'd3
    } t_cfg_reg;

    // Truncated atan(2^-i) in Q30 radians.
    function automatic logic [ANG_BITS-1:0] atan_q30(input int i);
        logic [ANG_BITS-1:0] v;
        unique case (i)
            0:  v = 30'd843314856;
            1:  v = 30'd497837829;
            2:  v = 30'd263043836;
            3:  v = 30'd133525158;
            4:  v = 30'd67021686;
            5:  v = 30'd33543515;
            6:  v = 30'd16775850;
            7:  v = 30'd8388437;
            8:  v = 30'd4194282;
            9:  v = 30'd2097149;
            10: v = 30'd1048575;
            11: v = 30'd524287;
            12: v = 30'd262143;
            13: v = 30'd131071;
            14: v = 30'd65535;
            15: v = 30'd32767;
            16: v = 30'd16383;
            17: v = 30'd8191;
            18: v = 30'd4095;
            19: v = 30'd2047;
            20: v = 30'd1023;
            21: v = 30'd511;
            22: v = 30'd255;
            23: v = 30'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/grid_to_quarter_annulus_mapper.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Grid to quarter-annulus mapper
// Maps one structured-grid node (column, row) onto a quarter annulus.
// ----------------------------------------------------------------------------
// Usage
//   A request is taken at a rising edge where start is high and busy is low.
//   busy is low at all times outside reset, so a new node may be offered in
//   every cycle: the block sustains one request per clock.
//   Each result appears on o_x_coord, o_y_coord and o_index_clamped for one
//   cycle, marked by o_valid, after its request has passed 43 divider stages,
//   16 CORDIC stages and five further register stages.
//   Most of the pipeline is the restoring divider, one quotient bit per
//   stage, that forms both the radius and the angle.
//   Results leave in request order. The receiver cannot stall the block, so
//   the pipeline simply advances every cycle.
//   The configuration registers are written through i_cfg_we, i_cfg_idx and
//   i_cfg_data and must only change while no request is in flight.
//   Reset is synchronous and active low: it restores the default registers
//   (radius 1.0 to 2.0, one column, one row) and drops all requests in
//   flight. No request is taken while reset is held.
// ----------------------------------------------------------------------------
module grid_to_quarter_annulus_mapper (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output      logic                                  busy,
    input  wire logic [gqam_pkg::INDEX_BITS-1:0]       i_col_index,
    input  wire logic [gqam_pkg::INDEX_BITS-1:0]       i_row_index,
    output      logic                                  o_valid,
    output      logic signed [gqam_pkg::COORD_BITS-1:0] o_x_coord,
    output      logic signed [gqam_pkg::COORD_BITS-1:0] o_y_coord,
    output      logic                                  o_index_clamped,
    input  wire logic                                  i_cfg_we,
    input  wire logic [1:0]                            i_cfg_idx,
    input  wire logic [gqam_pkg::COORD_BITS-1:0]       i_cfg_data
);
    import gqam_pkg::*;

    localparam int LAT = NUM_BITS + CORDIC_STEPS + 5;

    // Configuration registers.
    logic signed [COORD_BITS-1:0] r_x_min, r_x_max;
    logic [INDEX_BITS-1:0]        r_n_cols, r_n_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min  <= COORD_BITS'(65536);
            r_x_max  <= COORD_BITS'(131072);
            r_n_cols <= INDEX_BITS'(1);
            r_n_rows <= INDEX_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_X_MIN:  r_x_min  <= i_cfg_data;
                REG_X_MAX:  r_x_max  <= i_cfg_data;
                REG_N_COLS: r_n_cols <= i_cfg_data[INDEX_BITS-1:0];
                REG_N_ROWS: r_n_rows <= i_cfg_data[INDEX_BITS-1:0];
            endcase
        end
    end

    // A zero count behaves as a count of one.
    logic [INDEX_BITS-1:0] nc, nr;
    assign nc = (r_n_cols == '0) ? INDEX_BITS'(1) : r_n_cols;
    assign nr = (r_n_rows == '0) ? INDEX_BITS'(1) : r_n_rows;

    logic accept;
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // Stage A: clamp the indices against their counts.
    logic                  r_a_valid, r_a_clamp;
    logic [INDEX_BITS-1:0] r_a_col, r_a_row;
    logic                  col_over, row_over;
    assign col_over = i_col_index > nc;
    assign row_over = i_row_index > nr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
        end
        r_a_col   <= col_over ? nc : i_col_index;
        r_a_row   <= row_over ? nr : i_row_index;
        r_a_clamp <= col_over | row_over;
    end

    // Stage B: numerators of the radius and angle divisions.
    logic signed [SPAN_BITS-1:0] span;
    logic [SPAN_BITS-1:0]        span_mag;
    assign span     = {r_x_max[COORD_BITS-1], r_x_max} - {r_x_min[COORD_BITS-1], r_x_min};
    assign span_mag = span[SPAN_BITS-1] ? SPAN_BITS'(-span) : SPAN_BITS'(span);

    logic                r_b_valid, r_b_clamp, r_b_neg;
    logic [NUM_BITS-1:0] r_b_num_r, r_b_num_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_clamp <= r_a_clamp;
        r_b_neg   <= span[SPAN_BITS-1];
        r_b_num_r <= NUM_BITS'(r_a_col) * NUM_BITS'(span_mag);
        r_b_num_a <= NUM_BITS'(r_a_row) * NUM_BITS'(HALF_PI_Q30);
    end

    // Restoring division, one quotient bit per stage. The numerator register
    // shifts left and collects the quotient bits in its low end.
    function automatic logic [NUM_BITS+INDEX_BITS-1:0] div_step(
        input logic [NUM_BITS-1:0]   num,
        input logic [INDEX_BITS-1:0] rem,
        input logic [INDEX_BITS-1:0] den
    );
        logic [INDEX_BITS:0]   rem_sh;
        logic [INDEX_BITS:0]   diff;
        logic                  qbit;
        logic [INDEX_BITS-1:0] rem_nx;
        rem_sh = {rem, num[NUM_BITS-1]};
        diff   = rem_sh - {1'b0, den};
        qbit   = rem_sh >= {1'b0, den};
        rem_nx = qbit ? diff[INDEX_BITS-1:0] : rem_sh[INDEX_BITS-1:0];
        return {num[NUM_BITS-2:0], qbit, rem_nx};
    endfunction

    logic                  r_d_valid [NUM_BITS];
    logic                  r_d_clamp [NUM_BITS];
    logic                  r_d_neg   [NUM_BITS];
    logic [NUM_BITS-1:0]   r_d_num_r [NUM_BITS];
    logic [NUM_BITS-1:0]   r_d_num_a [NUM_BITS];
    logic [INDEX_BITS-1:0] r_d_rem_r [NUM_BITS];
    logic [INDEX_BITS-1:0] r_d_rem_a [NUM_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BITS; k++) begin
                r_d_valid[k] <= 1'b0;
            end
        end else begin
            r_d_valid[0] <= r_b_valid;
            for (int k = 1; k < NUM_BITS; k++) begin
                r_d_valid[k] <= r_d_valid[k-1];
            end
        end
        r_d_clamp[0] <= r_b_clamp;
        r_d_neg[0]   <= r_b_neg;
        {r_d_num_r[0], r_d_rem_r[0]} <= div_step(r_b_num_r, '0, nc);
        {r_d_num_a[0], r_d_rem_a[0]} <= div_step(r_b_num_a, '0, nr);
        for (int k = 1; k < NUM_BITS; k++) begin
            r_d_clamp[k] <= r_d_clamp[k-1];
            r_d_neg[k]   <= r_d_neg[k-1];
            {r_d_num_r[k], r_d_rem_r[k]} <= div_step(r_d_num_r[k-1], r_d_rem_r[k-1], nc);
            {r_d_num_a[k], r_d_rem_a[k]} <= div_step(r_d_num_a[k-1], r_d_rem_a[k-1], nr);
        end
    end

    // Stage C: radius from the signed quotient, and the start angle.
    logic [SPAN_BITS-1:0]        q_r;
    logic signed [SPAN_BITS:0]   q_r_s;
    logic signed [SPAN_BITS:0]   r_sum;
    assign q_r   = r_d_num_r[NUM_BITS-1][SPAN_BITS-1:0];
    assign q_r_s = r_d_neg[NUM_BITS-1] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    assign r_sum = (SPAN_BITS+1)'(r_x_min) + q_r_s;

    logic                         r_c_valid, r_c_clamp;
    logic signed [COORD_BITS-1:0] r_c_r;
    logic signed [ZW-1:0]         r_c_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_d_valid[NUM_BITS-1];
        end
        r_c_clamp <= r_d_clamp[NUM_BITS-1];
        r_c_r     <= r_sum[COORD_BITS-1:0];
        r_c_z     <= $signed({1'b0, r_d_num_a[NUM_BITS-1][ANG_BITS:0]});
    end

    // CORDIC rotation, one micro-rotation per stage.
    logic                         r_k_valid [CORDIC_STEPS];
    logic                         r_k_clamp [CORDIC_STEPS];
    logic signed [COORD_BITS-1:0] r_k_r     [CORDIC_STEPS];
    logic signed [CW-1:0]         r_k_x     [CORDIC_STEPS];
    logic signed [CW-1:0]         r_k_y     [CORDIC_STEPS];
    logic signed [ZW-1:0]         r_k_z     [CORDIC_STEPS];

    logic signed [CW-1:0] gain;
    logic signed [ZW-1:0] atan0;
    assign gain  = $signed({3'b000, CORDIC_GAIN_Q30});
    assign atan0 = $signed({2'b00, atan_q30(0)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_k_valid[k] <= 1'b0;
            end
        end else begin
            r_k_valid[0] <= r_c_valid;
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                r_k_valid[k] <= r_k_valid[k-1];
            end
        end
        // First step: y is zero, so only x feeds y.
        r_k_clamp[0] <= r_c_clamp;
        r_k_r[0]     <= r_c_r;
        if (!r_c_z[ZW-1]) begin
            r_k_x[0] <= gain;
            r_k_y[0] <= gain;
            r_k_z[0] <= r_c_z - atan0;
        end else begin
            r_k_x[0] <= gain;
            r_k_y[0] <= -gain;
            r_k_z[0] <= r_c_z + atan0;
        end
        for (int k = 1; k < CORDIC_STEPS; k++) begin
            r_k_clamp[k] <= r_k_clamp[k-1];
            r_k_r[k]     <= r_k_r[k-1];
            if (!r_k_z[k-1][ZW-1]) begin
                r_k_x[k] <= r_k_x[k-1] - (r_k_y[k-1] >>> k);
                r_k_y[k] <= r_k_y[k-1] + (r_k_x[k-1] >>> k);
                r_k_z[k] <= r_k_z[k-1] - $signed({2'b00, atan_q30(k)});
            end else begin
                r_k_x[k] <= r_k_x[k-1] + (r_k_y[k-1] >>> k);
                r_k_y[k] <= r_k_y[k-1] - (r_k_x[k-1] >>> k);
                r_k_z[k] <= r_k_z[k-1] + $signed({2'b00, atan_q30(k)});
            end
        end
    end

    // Stage M: scale the unit vector by the radius.
    logic                 r_m_valid, r_m_clamp;
    logic signed [PW-1:0] r_m_px, r_m_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= r_k_valid[CORDIC_STEPS-1];
        end
        r_m_clamp <= r_k_clamp[CORDIC_STEPS-1];
        r_m_px    <= PW'(r_k_r[CORDIC_STEPS-1]) * PW'(r_k_y[CORDIC_STEPS-1]);
        r_m_py    <= PW'(r_k_r[CORDIC_STEPS-1]) * PW'(r_k_x[CORDIC_STEPS-1]);
    end

    // Round to nearest (half up), drop the Q30 scale and saturate.
    function automatic logic [COORD_BITS-1:0] round_sat(input logic signed [PW:0] v);
        logic signed [PW:0] sh;
        logic               fits;
        sh   = (v + (PW+1)'(1 << (ANG_BITS - 1))) >>> ANG_BITS;
        fits = (&sh[PW:COORD_BITS-1]) | ~(|sh[PW:COORD_BITS-1]);
        if (fits) begin
            return sh[COORD_BITS-1:0];
        end else if (sh[PW]) begin
            return {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_BITS-1){1'b1}}};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_m_valid;
        end
        o_index_clamped <= r_m_clamp;
        o_x_coord       <= round_sat((PW+1)'(r_m_px));
        o_y_coord       <= round_sat(-((PW+1)'(r_m_py)));
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] r_lo, r_hi;
    assign r_lo = (r_x_min < r_x_max) ? r_x_min : r_x_max;
    assign r_hi = (r_x_min < r_x_max) ? r_x_max : r_x_min;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_valid)
        else $error("accepted request produced no result");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LAT))
        else $error("result without a matching request");

    a_radius_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> (r_c_r >= r_lo && r_c_r <= r_hi))
        else $error("radius outside the configured span");

endmodule
`default_nettype wire
